// ===== src/i2cmts_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmts_pkg: shared types for the i2c master transfer sequencer
// Request and result encodings, core commands, status codes and the
// structs passed between the top level and the control unit.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

    // number of buffer positions on the request side
    localparam int BYTE_SPAN = 256;

    typedef enum logic [2:0] {
        OP_LOAD_BYTE   = 3'd0,
        OP_START_WRITE = 3'd1,
        OP_START_READ  = 3'd2,
        OP_START_REG   = 3'd3,
        OP_CORE_DONE   = 3'd4,
        OP_READ_BYTE   = 3'd5
    } op_t;

    typedef enum logic [3:0] {
        CMD_NONE        = 4'd0,
        CMD_SINGLE_SEND = 4'd1,
        CMD_SEND_START  = 4'd2,
        CMD_SEND_CONT   = 4'd3,
        CMD_SEND_FINISH = 4'd4,
        CMD_SINGLE_RECV = 4'd5,
        CMD_RECV_START  = 4'd6,
        CMD_RECV_CONT   = 4'd7,
        CMD_RECV_FINISH = 4'd8
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_COMPLETE  = 3'd1,
        ST_FAILED    = 3'd2,
        ST_REJ_BUSY  = 3'd3,
        ST_REJ_COUNT = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        H_NONE  = 2'd0,
        H_WRITE = 2'd1,
        H_READ  = 2'd2
    } handler_t;

    // one captured request
    typedef struct packed {
        logic [2:0] operation;
        logic [6:0] target_address;
        logic [7:0] register_address;
        logic [7:0] byte_count;
        logic [7:0] buffer_index;
        logic [7:0] byte_value;
        logic       core_error;
        logic       core_busy;
    } item_t;

    // result fields before the buffer read data is merged in
    typedef struct packed {
        cmd_t       cmd;
        logic       tx_from_mem;
        logic [7:0] tx_byte;
        logic [6:0] bus_addr;
        logic       rd_dir;
        status_t    status;
        logic       rd_from_mem;
        logic       active;
    } res_t;

    // buffer access for one request
    typedef struct packed {
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic       re;
        logic [7:0] raddr;
    } mem_req_t;

endpackage

// ===== src/i2cmts_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2cmts_ctrl: transfer control unit
// Holds the transfer state and decides, for one request, the core command,
// status, state update and buffer access.
// ----------------------------------------------------------------------------
module i2cmts_ctrl
    import i2cmts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  item_t    item,
    output res_t     res,
    output mem_req_t mem
);

    logic [7:0] byte_index_reg, byte_index_next;
    logic [7:0] last_index_reg, last_index_next;
    handler_t   handler_reg, handler_next;
    logic       dir_read_reg, dir_read_next;
    logic       stopping_reg, stopping_next;
    logic       active_reg, active_next;
    logic       chain_reg, chain_next;
    logic [6:0] saved_addr_reg, saved_addr_next;
    logic [7:0] saved_count_reg, saved_count_next;

    op_t  op;
    logic start_busy;
    logic start_ok;
    logic is_single;
    logic saved_single;

    // request decode
    assign op           = op_t'(item.operation);
    assign start_busy   = active_reg || (item.core_busy && !stopping_reg);
    assign start_ok     = !start_busy && (item.byte_count != 8'd0);
    assign is_single    = (item.byte_count == 8'd1);
    assign saved_single = (saved_count_reg == 8'd1);

    // next state
    always_comb
    begin
        byte_index_next  = byte_index_reg;
        last_index_next  = last_index_reg;
        handler_next     = handler_reg;
        dir_read_next    = dir_read_reg;
        stopping_next    = stopping_reg;
        active_next      = active_reg;
        chain_next       = chain_reg;
        saved_addr_next  = saved_addr_reg;
        saved_count_next = saved_count_reg;
        case (op)
            OP_START_WRITE:
            begin
                if (start_ok)
                begin
                    active_next     = 1'b1;
                    stopping_next   = 1'b0;
                    chain_next      = 1'b0;
                    dir_read_next   = 1'b0;
                    last_index_next = item.byte_count - 8'd1;
                    byte_index_next = 8'd1;
                    handler_next    = is_single ? H_NONE : H_WRITE;
                end
            end
            OP_START_READ:
            begin
                if (start_ok)
                begin
                    active_next     = 1'b1;
                    chain_next      = 1'b0;
                    stopping_next   = 1'b0;
                    byte_index_next = 8'd0;
                    last_index_next = item.byte_count - 8'd1;
                    dir_read_next   = 1'b1;
                    handler_next    = is_single ? H_NONE : H_READ;
                end
            end
            OP_START_REG:
            begin
                if (start_ok)
                begin
                    active_next      = 1'b1;
                    saved_addr_next  = item.target_address;
                    saved_count_next = item.byte_count;
                    chain_next       = 1'b1;
                    stopping_next    = 1'b0;
                    dir_read_next    = 1'b0;
                    byte_index_next  = 8'd1;
                    last_index_next  = 8'd0;
                    handler_next     = H_NONE;
                end
            end
            OP_CORE_DONE:
            begin
                if (active_reg)
                begin
                    if (handler_reg == H_NONE)
                    begin
                        stopping_next = 1'b1;
                    end
                    if (item.core_error)
                    begin
                        handler_next = H_NONE;
                        active_next  = 1'b0;
                        chain_next   = 1'b0;
                    end
                    else
                    begin
                        case (handler_reg)
                            H_WRITE:
                            begin
                                if (byte_index_reg == last_index_reg)
                                begin
                                    handler_next = H_NONE;
                                end
                                byte_index_next = byte_index_reg + 8'd1;
                            end
                            H_READ:
                            begin
                                if (byte_index_reg == last_index_reg - 8'd1)
                                begin
                                    handler_next = H_NONE;
                                end
                                byte_index_next = byte_index_reg + 8'd1;
                            end
                            default:
                            begin
                                if (chain_reg)
                                begin
                                    // register address sent, now the read phase
                                    chain_next      = 1'b0;
                                    stopping_next   = 1'b0;
                                    byte_index_next = 8'd0;
                                    last_index_next = saved_count_reg - 8'd1;
                                    dir_read_next   = 1'b1;
                                    handler_next    = saved_single ? H_NONE : H_READ;
                                end
                                else
                                begin
                                    active_next = 1'b0;
                                end
                            end
                        endcase
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // result fields and buffer access
    always_comb
    begin
        res         = '0;
        res.cmd     = CMD_NONE;
        res.status  = ST_OK;
        res.active  = active_next;
        mem         = '0;
        mem.waddr   = item.buffer_index;
        mem.wdata   = item.byte_value;
        mem.raddr   = item.buffer_index;
        case (op)
            OP_LOAD_BYTE:
            begin
                mem.we = 1'b1;
            end
            OP_READ_BYTE:
            begin
                mem.re          = 1'b1;
                res.rd_from_mem = 1'b1;
            end
            OP_START_WRITE, OP_START_READ, OP_START_REG:
            begin
                if (start_busy)
                begin
                    res.status = ST_REJ_BUSY;
                end
                else if (item.byte_count == 8'd0)
                begin
                    res.status = ST_REJ_COUNT;
                end
                else
                begin
                    res.bus_addr = item.target_address;
                    case (op)
                        OP_START_WRITE:
                        begin
                            mem.re          = 1'b1;
                            mem.raddr       = 8'd0;
                            res.tx_from_mem = 1'b1;
                            res.cmd         = is_single ? CMD_SINGLE_SEND : CMD_SEND_START;
                        end
                        OP_START_READ:
                        begin
                            res.cmd    = is_single ? CMD_SINGLE_RECV : CMD_RECV_START;
                            res.rd_dir = 1'b1;
                        end
                        default:
                        begin
                            res.cmd     = CMD_SINGLE_SEND;
                            res.tx_byte = item.register_address;
                        end
                    endcase
                end
            end
            OP_CORE_DONE:
            begin
                if (active_reg)
                begin
                    // final received byte is stored even on error
                    if (handler_reg == H_NONE && dir_read_reg)
                    begin
                        mem.we    = 1'b1;
                        mem.waddr = byte_index_reg;
                    end
                    if (item.core_error)
                    begin
                        res.status = ST_FAILED;
                    end
                    else
                    begin
                        case (handler_reg)
                            H_WRITE:
                            begin
                                mem.re          = 1'b1;
                                mem.raddr       = byte_index_reg;
                                res.tx_from_mem = 1'b1;
                                res.cmd = (byte_index_reg == last_index_reg) ?
                                          CMD_SEND_FINISH : CMD_SEND_CONT;
                            end
                            H_READ:
                            begin
                                mem.we    = 1'b1;
                                mem.waddr = byte_index_reg;
                                res.cmd = (byte_index_reg == last_index_reg - 8'd1) ?
                                          CMD_RECV_FINISH : CMD_RECV_CONT;
                            end
                            default:
                            begin
                                if (chain_reg)
                                begin
                                    res.cmd      = saved_single ? CMD_SINGLE_RECV
                                                                : CMD_RECV_START;
                                    res.bus_addr = saved_addr_reg;
                                    res.rd_dir   = 1'b1;
                                end
                                else
                                begin
                                    res.status = ST_COMPLETE;
                                end
                            end
                        endcase
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg  <= 8'd0;
            last_index_reg  <= 8'd0;
            handler_reg     <= H_NONE;
            dir_read_reg    <= 1'b0;
            stopping_reg    <= 1'b0;
            active_reg      <= 1'b0;
            chain_reg       <= 1'b0;
            saved_addr_reg  <= 7'd0;
            saved_count_reg <= 8'd0;
        end
        else if (advance)
        begin
            byte_index_reg  <= byte_index_next;
            last_index_reg  <= last_index_next;
            handler_reg     <= handler_next;
            dir_read_reg    <= dir_read_next;
            stopping_reg    <= stopping_next;
            active_reg      <= active_next;
            chain_reg       <= chain_next;
            saved_addr_reg  <= saved_addr_next;
            saved_count_reg <= saved_count_next;
        end
    end

endmodule

// ===== src/i2c_master_transfer_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer: byte transfer sequencer for an i2c master
// Turns buffer loads, transfer starts and core done events into core
// commands, with a byte buffer for sent and received data.
// ----------------------------------------------------------------------------
// Every request gives exactly one result. The block takes one request per
// clock while no result is held stalled; an accepted request goes through
// the input register, then the result register with the buffer read.
// The byte buffer is a single memory with one write and one registered read
// port; buffer positions wrap modulo BUFFER_DEPTH. A request waits in the
// input register only while the result register holds a stalled result.
module i2c_master_transfer_sequencer
    import i2cmts_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] operation,
    input  logic [6:0] target_address,
    input  logic [7:0] register_address,
    input  logic [7:0] byte_count,
    input  logic [7:0] buffer_index,
    input  logic [7:0] byte_value,
    input  logic       core_error,
    input  logic       core_busy,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] core_command,
    output logic [7:0] tx_byte,
    output logic [6:0] bus_address,
    output logic       read_direction,
    output logic [2:0] status,
    output logic [7:0] read_byte,
    output logic       transfer_active
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    typedef logic [AW-1:0] slot_map_t [BYTE_SPAN];

    // position to buffer slot, worked out at elaboration
    function automatic slot_map_t slot_map_init();
        slot_map_t m;
        for (int i = 0; i < BYTE_SPAN; i++)
        begin
            m[i] = AW'(i % BUFFER_DEPTH);
        end
        return m;
    endfunction

    localparam slot_map_t SLOT_MAP = slot_map_init();

    logic       in_vld_reg;
    item_t      item_reg;
    logic       out_vld_reg;
    res_t       res_reg;
    logic [7:0] rdata_reg;

    logic       accept;
    logic       advance;
    res_t       res;
    mem_req_t   mem_req;

    logic [7:0] mem_array [BUFFER_DEPTH];

    // handshake
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign accept   = in_valid && !in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.operation        <= operation;
            item_reg.target_address   <= target_address;
            item_reg.register_address <= register_address;
            item_reg.byte_count       <= byte_count;
            item_reg.buffer_index     <= buffer_index;
            item_reg.byte_value       <= byte_value;
            item_reg.core_error       <= core_error;
            item_reg.core_busy        <= core_busy;
        end
    end

    // transfer control
    i2cmts_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .res     (res),
        .mem     (mem_req)
    );

    // byte buffer
    always_ff @(posedge clk)
    begin
        if (advance && mem_req.we)
        begin
            mem_array[SLOT_MAP[mem_req.waddr]] <= mem_req.wdata;
        end
        if (advance && mem_req.re)
        begin
            rdata_reg <= mem_array[SLOT_MAP[mem_req.raddr]];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    // outputs
    assign out_valid       = out_vld_reg;
    assign core_command    = res_reg.cmd;
    assign tx_byte         = res_reg.tx_from_mem ? rdata_reg : res_reg.tx_byte;
    assign bus_address     = res_reg.bus_addr;
    assign read_direction  = res_reg.rd_dir;
    assign status          = res_reg.status;
    assign read_byte       = res_reg.rd_from_mem ? rdata_reg : 8'd0;
    assign transfer_active = res_reg.active;

    // a command goes out only with an in-progress status
    assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && (res_reg.cmd != CMD_NONE) |-> (res_reg.status == ST_OK))
        else $error("core command issued with a final status");

    // a finished transfer leaves the sequencer idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && (res_reg.status == ST_COMPLETE || res_reg.status == ST_FAILED)
        |-> !res_reg.active)
        else $error("transfer still active after completion or failure");

    // address only travels with start commands
    assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !(res_reg.cmd == CMD_SINGLE_SEND || res_reg.cmd == CMD_SEND_START
        || res_reg.cmd == CMD_SINGLE_RECV || res_reg.cmd == CMD_RECV_START)
        |-> (res_reg.bus_addr == 7'd0))
        else $error("bus address without a start command");

    // a held request is not dropped while the result side stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && out_vld_reg && out_stall |=> in_vld_reg && out_vld_reg)
        else $error("request lost under output stall");

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for the i2c master transfer sequencer
// Drives buffer loads, transfer starts, core done events and buffer reads
// through the request channel. A request-level shadow of the sequencer
// predicts each result, and every result from the block is compared
// field by field against the oldest prediction. Directed sequences come
// first, then random transfers under three mixes of sender and receiver
// idling, with one long result hold-off that backs up the request side.
// ----------------------------------------------------------------------------
module tb;
    import i2cmts_pkg::*;

    localparam int DEPTH = 256;
    // cycles without any handshake before the run is declared hung
    localparam int HANG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int TAIL_CYCLES = 8;

    // request codes the block has no use for
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [3:0] command;
        logic [7:0] tx;
        logic [6:0] bus_addr;
        logic       dir;
        logic [2:0] stat;
        logic [7:0] rd_byte;
        logic       active;
    } core_reply_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] operation;
    logic [6:0] target_address;
    logic [7:0] register_address;
    logic [7:0] byte_count;
    logic [7:0] buffer_index;
    logic [7:0] byte_value;
    logic       core_error;
    logic       core_busy;
    logic       out_valid;
    logic       out_stall;
    logic [3:0] core_command;
    logic [7:0] tx_byte;
    logic [6:0] bus_address;
    logic       read_direction;
    logic [2:0] status;
    logic [7:0] read_byte;
    logic       transfer_active;

    // shadow of the sequencer state
    logic [7:0] shadow_buf [DEPTH];
    bit         shadow_known [DEPTH];
    int         written_slots [$];
    logic [7:0] seq_pos = 8'd0;
    logic [7:0] seq_last = 8'd0;
    handler_t   seq_next = H_NONE;
    logic       seq_dir_read = 1'b0;
    logic       seq_stopping = 1'b0;
    logic       seq_active = 1'b0;
    logic       seq_chain = 1'b0;
    logic [6:0] seq_saved_addr = 7'd0;
    logic [7:0] seq_saved_count = 8'd0;

    core_reply_t replies_due [$];
    core_reply_t head_reply;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;
    int mismatch_count = 0;
    int replies_checked = 0;
    int request_total = 0;
    int useful_count = 0;
    int n_complete = 0;
    int n_failed = 0;
    int n_rejected = 0;
    int stuck_cycles = 0;

    i2c_master_transfer_sequencer #(.BUFFER_DEPTH(DEPTH)) dut (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // shadow model
    // ------------------------------------------------------------------

    // buffer write, remembering which positions hold data
    function automatic void store_byte(input logic [7:0] idx, input logic [7:0] value);
        int s;
        s = idx % DEPTH;
        shadow_buf[s] = value;
        if (!shadow_known[s])
        begin
            shadow_known[s] = 1'b1;
            written_slots.push_back(s);
        end
    endfunction

    // first command of a read, also used for the second stage of a register read
    function automatic void open_read(input logic [6:0] addr, input logic [7:0] count,
                                      inout core_reply_t rep);
        seq_stopping = 1'b0;
        seq_pos = 8'd0;
        seq_last = count - 8'd1;
        seq_dir_read = 1'b1;
        if (count == 8'd1)
        begin
            rep.command = CMD_SINGLE_RECV;
            seq_next = H_NONE;
        end
        else
        begin
            rep.command = CMD_RECV_START;
            seq_next = H_READ;
        end
        rep.bus_addr = addr;
        rep.dir = 1'b1;
    endfunction

    // result of one request, advancing the shadow state
    function automatic core_reply_t sequence_step(input item_t req);
        core_reply_t rep;
        rep = '0;
        case (req.operation)
            OP_LOAD_BYTE:
                store_byte(req.buffer_index, req.byte_value);
            OP_READ_BYTE:
                rep.rd_byte = shadow_buf[req.buffer_index % DEPTH];
            OP_START_WRITE, OP_START_READ, OP_START_REG:
            begin
                if (seq_active || (req.core_busy && !seq_stopping))
                    rep.stat = ST_REJ_BUSY;
                else if (req.byte_count == 8'd0)
                    rep.stat = ST_REJ_COUNT;
                else
                begin
                    seq_active = 1'b1;
                    if (req.operation == OP_START_WRITE)
                    begin
                        seq_stopping = 1'b0;
                        seq_chain = 1'b0;
                        seq_dir_read = 1'b0;
                        seq_last = req.byte_count - 8'd1;
                        rep.tx = shadow_buf[0];
                        seq_pos = 8'd1;
                        if (req.byte_count == 8'd1)
                        begin
                            rep.command = CMD_SINGLE_SEND;
                            seq_next = H_NONE;
                        end
                        else
                        begin
                            rep.command = CMD_SEND_START;
                            seq_next = H_WRITE;
                        end
                        rep.bus_addr = req.target_address;
                    end
                    else if (req.operation == OP_START_READ)
                    begin
                        seq_chain = 1'b0;
                        open_read(req.target_address, req.byte_count, rep);
                    end
                    else
                    begin
                        // register byte goes out first, the read follows on done
                        seq_saved_addr = req.target_address;
                        seq_saved_count = req.byte_count;
                        seq_chain = 1'b1;
                        seq_stopping = 1'b0;
                        seq_dir_read = 1'b0;
                        seq_pos = 8'd1;
                        seq_last = 8'd0;
                        seq_next = H_NONE;
                        rep.command = CMD_SINGLE_SEND;
                        rep.tx = req.register_address;
                        rep.bus_addr = req.target_address;
                    end
                end
            end
            OP_CORE_DONE:
            begin
                if (seq_active)
                begin
                    // last byte of a stage: bus is being stopped, keep a received byte
                    if (seq_next == H_NONE)
                    begin
                        seq_stopping = 1'b1;
                        if (seq_dir_read)
                            store_byte(seq_pos, req.byte_value);
                    end
                    if (req.core_error)
                    begin
                        seq_next = H_NONE;
                        seq_active = 1'b0;
                        seq_chain = 1'b0;
                        rep.stat = ST_FAILED;
                    end
                    else if (seq_next == H_WRITE)
                    begin
                        rep.tx = shadow_buf[seq_pos % DEPTH];
                        if (seq_pos == seq_last)
                        begin
                            rep.command = CMD_SEND_FINISH;
                            seq_next = H_NONE;
                        end
                        else
                            rep.command = CMD_SEND_CONT;
                        seq_pos = seq_pos + 8'd1;
                    end
                    else if (seq_next == H_READ)
                    begin
                        store_byte(seq_pos, req.byte_value);
                        if (seq_pos == 8'(seq_last - 8'd1))
                        begin
                            rep.command = CMD_RECV_FINISH;
                            seq_next = H_NONE;
                        end
                        else
                            rep.command = CMD_RECV_CONT;
                        seq_pos = seq_pos + 8'd1;
                    end
                    else if (seq_chain)
                    begin
                        seq_chain = 1'b0;
                        open_read(seq_saved_addr, seq_saved_count, rep);
                    end
                    else
                    begin
                        seq_active = 1'b0;
                        rep.stat = ST_COMPLETE;
                    end
                end
            end
            default: ;
        endcase
        rep.active = seq_active;
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // random content in every field, callers overwrite what matters
    function automatic item_t random_fill();
        item_t r;
        r.operation = 3'($urandom_range(7));
        r.target_address = 7'($urandom_range(127));
        r.register_address = 8'($urandom);
        r.byte_count = 8'($urandom);
        r.buffer_index = 8'($urandom);
        r.byte_value = 8'($urandom);
        r.core_error = 1'($urandom_range(1));
        r.core_busy = 1'($urandom_range(1));
        return r;
    endfunction

    function automatic logic [7:0] pick_written();
        return 8'(written_slots[$urandom_range(written_slots.size() - 1)]);
    endfunction

    // offer one request, hold it until accepted, then queue its result
    task automatic send_request(input item_t req);
        core_reply_t rep;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        operation <= req.operation;
        target_address <= req.target_address;
        register_address <= req.register_address;
        byte_count <= req.byte_count;
        buffer_index <= req.buffer_index;
        byte_value <= req.byte_value;
        core_error <= req.core_error;
        core_busy <= req.core_busy;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        request_total++;
        if (!(req.operation > OP_READ_BYTE || (req.operation == OP_CORE_DONE && !seq_active)))
            useful_count++;
        rep = sequence_step(req);
        replies_due.push_back(rep);
        case (rep.stat)
            ST_COMPLETE: n_complete++;
            ST_FAILED: n_failed++;
            ST_REJ_BUSY, ST_REJ_COUNT: n_rejected++;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic load_byte(input logic [7:0] idx, input logic [7:0] value);
        item_t r;
        r = random_fill();
        r.operation = OP_LOAD_BYTE;
        r.buffer_index = idx;
        r.byte_value = value;
        send_request(r);
    endtask

    task automatic read_back(input logic [7:0] idx);
        item_t r;
        r = random_fill();
        r.operation = OP_READ_BYTE;
        r.buffer_index = idx;
        send_request(r);
    endtask

    task automatic start_transfer(input logic [2:0] op, input logic [6:0] addr,
                                  input logic [7:0] reg_addr, input logic [7:0] count,
                                  input logic busy);
        item_t r;
        r = random_fill();
        r.operation = op;
        r.target_address = addr;
        r.register_address = reg_addr;
        r.byte_count = count;
        r.core_busy = busy;
        send_request(r);
    endtask

    task automatic core_done(input logic [7:0] value, input logic err);
        item_t r;
        r = random_fill();
        r.operation = OP_CORE_DONE;
        r.byte_value = value;
        r.core_error = err;
        send_request(r);
    endtask

    task automatic stray_op(input logic [2:0] op);
        item_t r;
        r = random_fill();
        r.operation = op;
        send_request(r);
    endtask

    // sender goes quiet until every predicted result has been seen
    task automatic wait_replies_drained();
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // receiver stall, with an optional long hold-off
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (replies_due.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result with no request waiting", $time);
            end
            else
            begin
                head_reply = replies_due.pop_front();
                compare_field("core_command", 8'(head_reply.command), 8'(core_command));
                compare_field("tx_byte", head_reply.tx, tx_byte);
                compare_field("bus_address", 8'(head_reply.bus_addr), 8'(bus_address));
                compare_field("read_direction", 8'(head_reply.dir), 8'(read_direction));
                compare_field("status", 8'(head_reply.stat), 8'(status));
                compare_field("read_byte", head_reply.rd_byte, read_byte);
                compare_field("transfer_active", 8'(head_reply.active),
                              8'(transfer_active));
                replies_checked++;
            end
        end
    end

    // hang detector
    initial
    begin
        while (stuck_cycles < HANG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid === 1'b1 && in_stall === 1'b0)
                || (out_valid === 1'b1 && out_stall === 1'b0))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, HANG_LIMIT, replies_due.size());
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // buffer ends and extreme byte values
    task automatic test_buffer_extremes();
        load_byte(8'd0, 8'hFF);
        load_byte(8'd255, 8'h00);
        load_byte(8'd1, 8'hA5);
        load_byte(8'd128, 8'h5A);
        read_back(8'd255);
        read_back(8'd0);
        read_back(8'd128);
    endtask

    // single write, then a two-byte burst started with the core still busy
    // while the bus is being stopped
    task automatic test_write_sequences();
        start_transfer(OP_START_WRITE, 7'h7F, 8'h00, 8'd1, 1'b0);
        core_done(8'h00, 1'b0);
        start_transfer(OP_START_WRITE, 7'h00, 8'hFF, 8'd2, 1'b1);
        core_done(8'hFF, 1'b0);
        core_done(8'h00, 1'b0);
    endtask

    // two-byte burst read, then a one-byte register read
    task automatic test_read_sequences();
        start_transfer(OP_START_READ, 7'h55, 8'h00, 8'd2, 1'b0);
        core_done(8'hC3, 1'b0);
        core_done(8'h3C, 1'b0);
        start_transfer(OP_START_REG, 7'h2A, 8'hFF, 8'd1, 1'b0);
        core_done(8'h00, 1'b0);
        core_done(8'h96, 1'b0);
    endtask

    // ignored requests, rejected starts and a bus error mid-burst
    task automatic test_rejections();
        core_done(8'h11, 1'b0);
        start_transfer(OP_START_WRITE, 7'h12, 8'h34, 8'd0, 1'b0);
        stray_op(OP_SPARE_LO);
        stray_op(OP_SPARE_HI);
        start_transfer(OP_START_READ, 7'h33, 8'h00, 8'd2, 1'b0);
        start_transfer(OP_START_REG, 7'h44, 8'h80, 8'd255, 1'b0);
        core_done(8'hEE, 1'b1);
        start_transfer(OP_START_WRITE, 7'h01, 8'h00, 8'd1, 1'b1);
    endtask

    // results held off while requests keep coming, so the block backs up
    task automatic test_input_backpressure();
        int i;
        wait_replies_drained();
        send_idle_pct = 0;
        hold_req = HOLD_OFF_CYCLES;
        for (i = 0; i < 24; i++)
        begin
            if ($urandom_range(1))
                load_byte(8'($urandom), 8'($urandom));
            else
                read_back(pick_written());
        end
        wait_replies_drained();
    endtask

    // one software transfer with random content, plus some noise around it
    task automatic run_transfer();
        int kind;
        int roll;
        int i;
        logic [7:0] count;
        logic [2:0] op;
        kind = $urandom_range(2);
        roll = $urandom_range(99);
        if (roll < 55)
            count = 8'($urandom_range(3, 1));
        else if (roll < 90)
            count = 8'($urandom_range(16, 4));
        else if (roll < 97)
            count = 8'($urandom_range(64, 17));
        else
            count = 8'($urandom_range(255, 65));
        if ($urandom_range(99) < 4)
            count = 8'd0;
        op = (kind == 0) ? OP_START_WRITE : (kind == 1) ? OP_START_READ : OP_START_REG;
        // software fills the bytes a write will send
        if (kind == 0)
        begin
            for (i = 0; i < count; i++)
            begin
                if (!shadow_known[i] || $urandom_range(1))
                    load_byte(8'(i), 8'($urandom));
            end
        end
        start_transfer(op, 7'($urandom_range(127)), 8'($urandom), count,
                       $urandom_range(99) < 8);
        while (seq_active)
        begin
            roll = $urandom_range(99);
            if (roll < 4)
                read_back(pick_written());
            else if (roll < 7)
                start_transfer(3'($urandom_range(3, 1)), 7'($urandom_range(127)),
                               8'($urandom), 8'($urandom), 1'($urandom_range(1)));
            else if (roll < 8)
                stray_op(3'($urandom_range(7, 6)));
            else if (roll < 9)
                load_byte(8'($urandom), 8'($urandom));
            else
                core_done(8'($urandom), $urandom_range(99) < 3);
        end
        if ($urandom_range(99) < 30)
            read_back(pick_written());
        if ($urandom_range(99) < 5)
            core_done(8'($urandom), 1'($urandom_range(1)));
    endtask

    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
        int goal;
        wait_replies_drained();
        send_idle_pct = send_pct;
        stall_pct = recv_pct;
        goal = useful_count + count;
        while (useful_count < goal)
            run_transfer();
    endtask

    // main sequence
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = '0;
        target_address = '0;
        register_address = '0;
        byte_count = '0;
        buffer_index = '0;
        byte_value = '0;
        core_error = 1'b0;
        core_busy = 1'b0;
        send_idle_pct = 15;
        stall_pct = 67;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_buffer_extremes();
        test_write_sequences();
        test_read_sequences();
        test_rejections();
        test_input_backpressure();
        test_random_traffic(600, 15, 67);
        test_random_traffic(600, 67, 15);
        test_random_traffic(600, 0, 0);

        wait_replies_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("covered %0d requests, %0d results: %0d complete, %0d failed, %0d rejected",
                 request_total, replies_checked, n_complete, n_failed, n_rejected);
        $display("idling mixes 15/67, 67/15 and none, plus a %0d-cycle result hold-off",
                 HOLD_OFF_CYCLES);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
